/* hdl/sfd_pkg.sv */
// Shared types and constants for the SBUS frame decoder.
// No dependencies; imported by every module of the decoder except sfd_ram.
package sfd_pkg;

  localparam int BYTE_W          = 8;
  localparam int PAYLOAD_BYTES   = 24;
  localparam int ANALOG_CHANNELS = 16;
  localparam int CHAN_W          = 11;
  localparam int FLAG_BYTE       = 22;
  localparam int ANALOG_BYTES    = ANALOG_CHANNELS * CHAN_W / 8;
  localparam int IDX_W           = $clog2(PAYLOAD_BYTES);
  localparam int CNT_W           = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W          = IDX_W + 1;
  localparam int ACC_W           = CHAN_W - 1 + BYTE_W;
  localparam int NBITS_W         = $clog2(ACC_W + 1);
  localparam int CH_NUM_W        = $clog2(ANALOG_CHANNELS);
  localparam int OUT_IDX_W       = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int TOKQ_DEPTH      = 2;
  localparam int TOKQ_PTR_W      = $clog2(TOKQ_DEPTH);
  localparam int TOKQ_CNT_W      = $clog2(TOKQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER,
    REG_FOOTER,
    REG_DIG_A,
    REG_DIG_B,
    REG_LOST,
    REG_FAILSAFE
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] footer;
    logic [BYTE_W-1:0] dig_a_mask;
    logic [BYTE_W-1:0] dig_b_mask;
    logic [BYTE_W-1:0] lost_mask;
    logic [BYTE_W-1:0] fs_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    header:     8'h0F,
    footer:     8'h00,
    dig_a_mask: 8'h01,
    dig_b_mask: 8'h02,
    lost_mask:  8'h04,
    fs_mask:    8'h08
  };

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic bank;
  } tokq_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLAG,
    BK_RUN,
    BK_DIG_A,
    BK_DIG_B
  } bk_state_t;

endpackage

/* hdl/sfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds both payload banks; no package dependency.
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/sfd_front.sv */
// Byte front end: header/footer framing, byte count and payload writes.
// Depends on sfd_pkg; hands finished frames to the token queue.
module sfd_front
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  cfg_t              cfg,
  input  logic              q_full,
  output ram_wr_t           wr,
  output logic              tok_push,
  output logic              tok_bank
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic              bank_r, bank_nxt;
  logic              accept;
  logic              start;
  logic              last_byte;

  assign accept    = in_push && !q_full;
  assign start     = (in_rx_byte == cfg.header) && (prev_r == cfg.footer);
  assign last_byte = (count_r == CNT_W'(PAYLOAD_BYTES - 1));

  always_comb begin
    count_nxt = count_r;
    prev_nxt  = prev_r;
    bank_nxt  = bank_r;
    wr.en     = 1'b0;
    wr.addr   = {bank_r, count_r[IDX_W-1:0]};
    wr.data   = in_rx_byte;
    tok_push  = 1'b0;
    tok_bank  = bank_r;
    if (accept) begin
      prev_nxt = in_rx_byte;
      if (start) begin
        count_nxt = '0;
      end else begin
        wr.en = 1'b1;
        if (last_byte) begin
          count_nxt = '0;
          prev_nxt  = cfg.footer;
          tok_push  = 1'b1;
          bank_nxt  = ~bank_r;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= CFG_RESET.footer;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
      bank_r  <= bank_nxt;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    tok_push |=> (count_r == '0) && (prev_r == $past(cfg.footer)))
    else $error("front did not restart after a frame");

endmodule

/* hdl/sfd_token_q.sv */
// Two-entry queue of finished-frame tokens (payload bank ids).
// Depends on sfd_pkg; sits between front end and back end.
module sfd_token_q
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       push_bank,
  input  logic       pop,
  output tokq_stat_t stat
);

  logic                  bank_q_r [TOKQ_DEPTH];
  logic [TOKQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [TOKQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [TOKQ_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == TOKQ_CNT_W'(TOKQ_DEPTH));
    stat.bank  = bank_q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      bank_q_r[wr_ptr_r] <= push_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("token queue popped while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((cnt_r != TOKQ_CNT_W'(TOKQ_DEPTH)) || pop))
    else $error("token queue pushed while full");

endmodule

/* hdl/sfd_back.sv */
// Back end: reads one payload bank, unpacks channels and drives the result register.
// Depends on sfd_pkg; reads the payload RAM and pops the token queue.
module sfd_back
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  tokq_stat_t           tq,
  input  logic [BYTE_W-1:0]    rd_data,
  output ram_rd_t              rd,
  output logic                 tok_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [OUT_IDX_W-1:0] out_channel_index,
  output logic [CHAN_W-1:0]    out_channel_value,
  output logic                 out_failsafe,
  output logic                 out_frame_lost,
  output logic                 out_last_of_frame
);

  bk_state_t            state_r, state_nxt;
  logic [BYTE_W-1:0]    flags_r, flags_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [NBITS_W-1:0]   nbits_r, nbits_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CH_NUM_W-1:0]  ch_r, ch_nxt;
  logic                 inflight_r, inflight_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_index_r, out_index_nxt;
  logic [CHAN_W-1:0]    out_value_r, out_value_nxt;
  logic                 out_fs_r, out_fs_nxt;
  logic                 out_lf_r, out_lf_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 slot_free;
  logic                 fs;
  logic                 lf;

  assign slot_free = !out_valid_r || out_pop;
  assign fs        = |(flags_r & cfg.fs_mask);
  assign lf        = |(flags_r & cfg.lost_mask);

  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    acc_nxt       = acc_r;
    nbits_nxt     = nbits_r;
    rd_idx_nxt    = rd_idx_r;
    ch_nxt        = ch_r;
    inflight_nxt  = inflight_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_fs_nxt    = out_fs_r;
    out_lf_nxt    = out_lf_r;
    out_last_nxt  = out_last_r;
    rd.en         = 1'b0;
    rd.addr       = {tq.bank, rd_idx_r};
    tok_pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!tq.empty) begin
          rd.en     = 1'b1;
          rd.addr   = {tq.bank, IDX_W'(FLAG_BYTE)};
          state_nxt = BK_FLAG;
        end
      end
      BK_FLAG: begin
        flags_nxt    = rd_data;
        acc_nxt      = '0;
        nbits_nxt    = '0;
        rd_idx_nxt   = '0;
        ch_nxt       = '0;
        inflight_nxt = 1'b0;
        state_nxt    = BK_RUN;
      end
      BK_RUN: begin
        if (inflight_r) begin
          acc_nxt      = acc_r | (ACC_W'(rd_data) << nbits_r);
          nbits_nxt    = nbits_r + NBITS_W'(BYTE_W);
          inflight_nxt = 1'b0;
        end else if (nbits_r < NBITS_W'(CHAN_W)) begin
          rd.en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          inflight_nxt = 1'b1;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = OUT_IDX_W'(ch_r);
          out_value_nxt = acc_r[CHAN_W-1:0];
          out_fs_nxt    = fs;
          out_lf_nxt    = lf;
          out_last_nxt  = 1'b0;
          acc_nxt       = acc_r >> CHAN_W;
          nbits_nxt     = nbits_r - NBITS_W'(CHAN_W);
          ch_nxt        = ch_r + 1'b1;
          if (ch_r == CH_NUM_W'(ANALOG_CHANNELS - 1)) begin
            state_nxt = BK_DIG_A;
          end
        end
      end
      BK_DIG_A: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = OUT_IDX_W'(ANALOG_CHANNELS);
          out_value_nxt = CHAN_W'(|(flags_r & cfg.dig_a_mask));
          out_fs_nxt    = fs;
          out_lf_nxt    = lf;
          out_last_nxt  = 1'b0;
          state_nxt     = BK_DIG_B;
        end
      end
      BK_DIG_B: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = OUT_IDX_W'(ANALOG_CHANNELS + 1);
          out_value_nxt = CHAN_W'(|(flags_r & cfg.dig_b_mask));
          out_fs_nxt    = fs;
          out_lf_nxt    = lf;
          out_last_nxt  = 1'b1;
          tok_pop       = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r     <= flags_nxt;
    acc_r       <= acc_nxt;
    nbits_r     <= nbits_nxt;
    rd_idx_r    <= rd_idx_nxt;
    ch_r        <= ch_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_fs_r    <= out_fs_nxt;
    out_lf_r    <= out_lf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_empty         = !out_valid_r;
  assign out_channel_index = out_index_r;
  assign out_channel_value = out_value_r;
  assign out_failsafe      = out_fs_r;
  assign out_frame_lost    = out_lf_r;
  assign out_last_of_frame = out_last_r;

  a_fetch_only_short: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r |-> (state_r == BK_RUN) && (nbits_r < NBITS_W'(CHAN_W)))
    else $error("byte fetch in flight with a full channel buffered");

  a_token_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !tq.empty)
    else $error("back end working without a frame token");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |=> out_valid_r && out_last_r)
    else $error("frame released without its last word");

endmodule

/* hdl/sbus_frame_decoder.sv */
// Input: one byte per cycle while in_full is low; in_full rises only while both payload banks await unpacking.
// First word of a frame: after its last byte come the token queue entry, the flag byte
// read, two payload byte fetches and the result register. A frame yields 18 words; the
// payload RAM's one read port bounds unpacking, while the front end fills the other bank.
// Reset: synchronous, active low; clears counters, queues and config to defaults.
// The payload RAM is not cleared: every entry read is written first.
module sbus_frame_decoder
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [OUT_IDX_W-1:0] out_channel_index,
  output logic [CHAN_W-1:0]    out_channel_value,
  output logic                 out_failsafe,
  output logic                 out_frame_lost,
  output logic                 out_last_of_frame,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  cfg_t              cfg_r;
  ram_wr_t           wr;
  ram_rd_t           rd;
  tokq_stat_t        tq;
  logic              tok_push;
  logic              tok_bank;
  logic              tok_pop;
  logic [BYTE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER:   cfg_r.header     <= cfg_data;
        REG_FOOTER:   cfg_r.footer     <= cfg_data;
        REG_DIG_A:    cfg_r.dig_a_mask <= cfg_data;
        REG_DIG_B:    cfg_r.dig_b_mask <= cfg_data;
        REG_LOST:     cfg_r.lost_mask  <= cfg_data;
        REG_FAILSAFE: cfg_r.fs_mask    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_full = tq.full;

  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg_r),
    .q_full     (tq.full),
    .wr         (wr),
    .tok_push   (tok_push),
    .tok_bank   (tok_bank)
  );

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  sfd_token_q u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_push),
    .push_bank (tok_bank),
    .pop       (tok_pop),
    .stat      (tq)
  );

  sfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .tq                (tq),
    .rd_data           (rd_data),
    .rd                (rd),
    .tok_pop           (tok_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_failsafe      (out_failsafe),
    .out_frame_lost    (out_frame_lost),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
